// File: sv/wrpc_pkg.sv
// Package: constants, types and helpers for the weighted residue pair counter.
package wrpc_pkg;

    localparam int MAX_SEQS_DEF  = 64;
    localparam int MAX_WIDTH_DEF = 64;
    localparam int ALPHABET_DEF  = 20;
    localparam int FRAC_BITS_DEF = 16;

    localparam int ENTRY_W  = 48;
    localparam int PAIRS_W  = 40;
    localparam int BLOCKS_W = 32;
    localparam int BPAIRS_W = 17;
    localparam int RES_W    = 5;
    localparam int SLOT_W   = 6;
    localparam int COL_W    = 6;
    localparam int LABEL_W  = 6;
    localparam int SIZE_W   = 7;
    localparam int IDX_W    = 5;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_CLOSE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    localparam logic [1:0] REG_PAIRING_MODE = 2'd0;

    typedef struct packed {
        logic                  valid;
        logic                  is_close;
        logic [BPAIRS_W-1:0]   block_pairs;
        logic                  block_used;
        logic [ENTRY_W-1:0]    entry_value;
        logic [PAIRS_W-1:0]    pairs_total;
        logic [ENTRY_W-1:0]    weight_total;
        logic [BLOCKS_W-1:0]   blocks_total;
    } result_t;

endpackage

// File: sv/weighted_residue_pair_counter.sv
// Top level: weighted residue pair counter with close-time pair walk.
//
//  channel | dir | fields
//  s_axis  | in  | tdata: func, residue, seq_slot, column, cluster_label,
//          |     |        cluster_count, read_row, read_col
//  m_axis  | out | tdata: block_pairs, block_used, entry_value, pairs_total,
//          |     |        weight_total, blocks_total
//  apb     | cfg | register 0 pairing_mode
//
// Load: written to the block store from ST_IDLE. Read: ST_RD1, ST_RD2, then
// ST_OUT. Close: per column, for each row i a scan over rows j>i, each valid
// pair costing a matrix read-modify-write (ST_DIV first in cluster mode).
// After reset a clearing pass zeroes all ALPHABET^2 entries of the matrix;
// no transaction is taken meanwhile. A stalled result holds the block busy.
module weighted_residue_pair_counter
    import wrpc_pkg::*;
#(
    parameter int MAX_SEQS  = MAX_SEQS_DEF,
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int ALPHABET  = ALPHABET_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func[1:0] residue[6:2] seq_slot[12:7] column[18:13] cluster_label[24:19]
    // cluster_count[31:25] read_row[36:32] read_col[41:37]
    input  logic [47:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // block_pairs[16:0] block_used[17] entry_value[65:18] pairs_total[105:66]
    // weight_total[153:106] blocks_total[185:154]
    output logic [191:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int SW  = $clog2(MAX_SEQS);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int NE  = ALPHABET * ALPHABET;
    localparam int AW  = $clog2(NE);
    localparam int RCW = SW + 1;
    localparam int CCW = CW + 1;
    localparam logic [ENTRY_W-1:0]  SAT48 = '1;
    localparam logic [PAIRS_W-1:0]  SAT40 = '1;
    localparam logic [BLOCKS_W-1:0] SAT32 = '1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_CI, ST_CIW, ST_CJ, ST_CJW, ST_DIV, ST_MRD, ST_MWR,
        ST_RD1, ST_RD2, ST_OUT
    } state_t;

    state_t state_reg;

    logic [1:0]         in_func;
    logic [RES_W-1:0]   in_res;
    logic [SLOT_W-1:0]  in_slot;
    logic [COL_W-1:0]   in_col;
    logic [LABEL_W-1:0] in_label;
    logic [SIZE_W-1:0]  in_size;
    logic [IDX_W-1:0]   in_rrow, in_rcol;

    assign in_func  = s_tdata[1:0];
    assign in_res   = s_tdata[6:2];
    assign in_slot  = s_tdata[12:7];
    assign in_col   = s_tdata[18:13];
    assign in_label = s_tdata[24:19];
    assign in_size  = s_tdata[31:25];
    assign in_rrow  = s_tdata[36:32];
    assign in_rcol  = s_tdata[41:37];

    logic mode_reg;
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == REG_PAIRING_MODE) ? {31'd0, mode_reg} : 32'd0;

    logic [RCW-1:0]      rows_reg;
    logic [CCW-1:0]      cols_reg;
    logic [CW-1:0]       c_reg;
    logic [SW-1:0]       i_reg, j_reg;
    logic [RES_W-1:0]    ri_reg, rj_reg;
    logic [LABEL_W-1:0]  li_reg;
    logic [SIZE_W-1:0]   si_reg;
    logic [ENTRY_W-1:0]  w_reg;
    logic [PAIRS_W-1:0]  ptally_reg;
    logic [ENTRY_W-1:0]  wtally_reg;
    logic [BLOCKS_W-1:0] btally_reg;
    logic [BPAIRS_W-1:0] bpairs_reg;
    logic                bused_reg;
    logic [AW-1:0]       clr_reg;
    logic [AW-1:0]       raddr_reg;
    logic                rvalid_reg;
    result_t             res_reg;

    logic               acc;
    logic               st_we;
    logic [SW-1:0]      st_rslot;
    logic [CW-1:0]      st_rcol;
    logic [RES_W-1:0]   st_res;
    logic [LABEL_W-1:0] st_label;
    logic [SIZE_W-1:0]  st_size;
    logic               mx_we;
    logic [AW-1:0]      mx_waddr, mx_raddr;
    logic [ENTRY_W-1:0] mx_wdata, mx_rdata;
    logic               div_start, div_done;
    logic [FRAC_BITS:0] div_q;
    logic [SIZE_W-1:0]  sj_fix, si_fix;
    logic [ENTRY_W:0]   msum, wsum;
    logic [AW-1:0]      pair_addr;
    logic               slot_ok, col_ok;

    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign slot_ok  = {1'b0, in_slot} < 7'(MAX_SEQS);
    assign col_ok   = {1'b0, in_col} < 7'(MAX_WIDTH);
    assign st_we    = acc && (in_func == FUNC_LOAD) && slot_ok && col_ok;

    assign pair_addr = AW'(ri_reg * ALPHABET) + AW'(rj_reg);
    assign msum      = {1'b0, mx_rdata} + {1'b0, w_reg};
    assign wsum      = {1'b0, wtally_reg} + {1'b0, w_reg};
    assign si_fix    = (si_reg == '0) ? SIZE_W'(1) : si_reg;
    assign sj_fix    = (st_size == '0) ? SIZE_W'(1) : st_size;
    assign div_start = (state_reg == ST_CJW) && mode_reg && (st_res < RES_W'(ALPHABET))
                       && (st_label != li_reg);

    always_comb begin
        st_rslot = i_reg;
        st_rcol  = c_reg;
        if (state_reg == ST_CJ || state_reg == ST_CJW) begin
            st_rslot = j_reg;
        end
        mx_we    = 1'b0;
        mx_waddr = pair_addr;
        mx_wdata = msum[ENTRY_W] ? SAT48 : msum[ENTRY_W-1:0];
        mx_raddr = pair_addr;
        if (state_reg == ST_CLEAR) begin
            mx_we    = 1'b1;
            mx_waddr = clr_reg;
            mx_wdata = '0;
        end else if (state_reg == ST_MWR) begin
            mx_we = 1'b1;
        end else if (state_reg == ST_RD1) begin
            mx_raddr = raddr_reg;
        end
    end

    wrpc_block_store #(.MAX_SEQS(MAX_SEQS), .MAX_WIDTH(MAX_WIDTH)) u_store (
        .aclk(aclk), .wr_en(st_we), .wr_slot(in_slot[SW-1:0]), .wr_col(in_col[CW-1:0]),
        .wr_res(in_res), .wr_label(in_label), .wr_size(in_size),
        .rd_slot(st_rslot), .rd_col(st_rcol),
        .rd_res(st_res), .rd_label(st_label), .rd_size(st_size)
    );

    wrpc_matrix #(.ALPHABET(ALPHABET)) u_matrix (
        .aclk(aclk), .wr_en(mx_we), .wr_addr(mx_waddr), .wr_data(mx_wdata),
        .rd_addr(mx_raddr), .rd_data(mx_rdata)
    );

    wrpc_weight_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .divisor((2*SIZE_W)'(si_fix) * (2*SIZE_W)'(sj_fix)),
        .done(div_done), .quotient(div_q)
    );

    // True when row i is the last to scan: then next column or finish, else next row.
    function automatic logic last_row_i(input logic [SW-1:0] i, input logic [RCW-1:0] rows);
        last_row_i = (RCW'(i) + RCW'(2)) >= rows;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            mode_reg   <= 1'b1;
            rows_reg   <= '0;
            cols_reg   <= '0;
            ptally_reg <= '0;
            wtally_reg <= '0;
            btally_reg <= '0;
            res_reg    <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr && paddr == REG_PAIRING_MODE) begin
                mode_reg <= pwdata[0];
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(NE - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (acc) begin
                        case (in_func)
                            FUNC_LOAD: begin
                                if (slot_ok && col_ok) begin
                                    if (RCW'(in_slot) + 1'b1 > rows_reg)
                                        rows_reg <= RCW'(in_slot) + 1'b1;
                                    if (CCW'(in_col) + 1'b1 > cols_reg)
                                        cols_reg <= CCW'(in_col) + 1'b1;
                                end
                            end
                            FUNC_CLOSE: begin
                                c_reg      <= '0;
                                i_reg      <= '0;
                                bpairs_reg <= '0;
                                bused_reg  <= 1'b0;
                                if (rows_reg < RCW'(2) || cols_reg == '0)
                                    state_reg <= ST_OUT;
                                else
                                    state_reg <= ST_CI;
                            end
                            FUNC_READ: begin
                                rvalid_reg <= (in_rrow < IDX_W'(ALPHABET))
                                              && (in_rcol < IDX_W'(ALPHABET));
                                raddr_reg  <= AW'(in_rrow * ALPHABET) + AW'(in_rcol);
                                state_reg  <= ST_RD1;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CI: state_reg <= ST_CIW;
                ST_CIW: begin
                    ri_reg <= st_res;
                    li_reg <= st_label;
                    si_reg <= st_size;
                    j_reg  <= i_reg + 1'b1;
                    if (st_res < RES_W'(ALPHABET)) begin
                        state_reg <= ST_CJ;
                    end else if (last_row_i(i_reg, rows_reg)) begin
                        i_reg <= '0;
                        c_reg <= c_reg + 1'b1;
                        state_reg <= (CCW'(c_reg) + 1'b1 >= cols_reg) ? ST_OUT : ST_CI;
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_CI;
                    end
                end
                ST_CJ: state_reg <= ST_CJW;
                ST_CJW: begin
                    rj_reg <= st_res;
                    w_reg  <= ENTRY_W'(1) << FRAC_BITS;
                    if (st_res < RES_W'(ALPHABET) && (!mode_reg || st_label != li_reg)) begin
                        state_reg <= mode_reg ? ST_DIV : ST_MRD;
                    end else if (RCW'(j_reg) + 1'b1 < rows_reg) begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_CJ;
                    end else if (last_row_i(i_reg, rows_reg)) begin
                        i_reg <= '0;
                        c_reg <= c_reg + 1'b1;
                        state_reg <= (CCW'(c_reg) + 1'b1 >= cols_reg) ? ST_OUT : ST_CI;
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_CI;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        w_reg     <= ENTRY_W'(div_q);
                        state_reg <= ST_MRD;
                    end
                end
                ST_MRD: state_reg <= ST_MWR;
                ST_MWR: begin
                    ptally_reg <= (ptally_reg == SAT40) ? SAT40 : ptally_reg + 1'b1;
                    wtally_reg <= wsum[ENTRY_W] ? SAT48 : wsum[ENTRY_W-1:0];
                    if (bpairs_reg != '1) bpairs_reg <= bpairs_reg + 1'b1;
                    if (w_reg != '0) bused_reg <= 1'b1;
                    if (RCW'(j_reg) + 1'b1 < rows_reg) begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_CJ;
                    end else if (last_row_i(i_reg, rows_reg)) begin
                        i_reg <= '0;
                        c_reg <= c_reg + 1'b1;
                        state_reg <= (CCW'(c_reg) + 1'b1 >= cols_reg) ? ST_OUT : ST_CI;
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_CI;
                    end
                end
                ST_RD1: state_reg <= ST_RD2;
                ST_RD2: begin
                    res_reg.valid        <= 1'b1;
                    res_reg.is_close     <= 1'b0;
                    res_reg.block_pairs  <= '0;
                    res_reg.block_used   <= 1'b0;
                    res_reg.entry_value  <= rvalid_reg ? mx_rdata : '0;
                    res_reg.pairs_total  <= ptally_reg;
                    res_reg.weight_total <= wtally_reg;
                    res_reg.blocks_total <= btally_reg;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!res_reg.valid) begin
                        res_reg.valid        <= 1'b1;
                        res_reg.is_close     <= 1'b1;
                        res_reg.block_pairs  <= bpairs_reg;
                        res_reg.block_used   <= bused_reg;
                        res_reg.entry_value  <= '0;
                        res_reg.pairs_total  <= ptally_reg;
                        res_reg.weight_total <= wtally_reg;
                        if (!mode_reg || bused_reg) begin
                            res_reg.blocks_total <= (btally_reg == SAT32) ? SAT32
                                                    : btally_reg + 1'b1;
                            btally_reg <= (btally_reg == SAT32) ? SAT32 : btally_reg + 1'b1;
                        end else begin
                            res_reg.blocks_total <= btally_reg;
                        end
                        rows_reg <= '0;
                        cols_reg <= '0;
                    end else if (m_tready) begin
                        res_reg.valid <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = res_reg.valid;
    assign m_tdata  = {6'd0, res_reg.blocks_total, res_reg.weight_total, res_reg.pairs_total,
                       res_reg.entry_value, res_reg.block_used, res_reg.block_pairs};

    logic unused_in;
    assign unused_in = ^{s_tdata[47:42], pwdata[31:1], res_reg.is_close};

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !m_tvalid) else $error("accept with result pending");
    a_clear_first: assert property (@(posedge aclk)
        $past(!aresetn) && aresetn |-> !s_tready) else $error("ready during clear");
    a_tally_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> ptally_reg >= $past(ptally_reg)) else $error("pair tally fell");
    a_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_reg.is_close |-> res_reg.entry_value == '0)
        else $error("close result carries entry");
endmodule

// File: sv/wrpc_weight_div.sv
// Iterative divider: weight = floor(2^FRAC_BITS / (si*sj)), one quotient bit per cycle.
module wrpc_weight_div
    import wrpc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [2*SIZE_W-1:0]    divisor,
    output logic                   done,
    output logic [FRAC_BITS:0]     quotient
);
    localparam int QW = FRAC_BITS + 1;
    localparam int RW = 2*SIZE_W + 1;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0]       num_reg, num_next;
    logic [RW-1:0]       rem_reg, rem_next;
    logic [2*SIZE_W-1:0] den_reg, den_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [RW-1:0]       trial;

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[RW-2:0], num_reg[QW-1]};
        if (start) begin
            num_next  = {1'b1, {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            den_next  = (divisor == '0) ? {{(2*SIZE_W-1){1'b0}}, 1'b1} : divisor;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                num_next = {num_reg[QW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                num_next = {num_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;
endmodule

// File: sv/wrpc_block_store.sv
// Block store: residue, label and size memories with one registered read port.
module wrpc_block_store
    import wrpc_pkg::*;
#(
    parameter int MAX_SEQS  = MAX_SEQS_DEF,
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_SEQS)-1:0]   wr_slot,
    input  logic [$clog2(MAX_WIDTH)-1:0]  wr_col,
    input  logic [RES_W-1:0]              wr_res,
    input  logic [LABEL_W-1:0]            wr_label,
    input  logic [SIZE_W-1:0]             wr_size,
    input  logic [$clog2(MAX_SEQS)-1:0]   rd_slot,
    input  logic [$clog2(MAX_WIDTH)-1:0]  rd_col,
    output logic [RES_W-1:0]              rd_res,
    output logic [LABEL_W-1:0]            rd_label,
    output logic [SIZE_W-1:0]             rd_size
);
    logic [RES_W-1:0]   res_mem [MAX_SEQS*MAX_WIDTH];
    logic [LABEL_W-1:0] label_mem [MAX_SEQS];
    logic [SIZE_W-1:0]  size_mem [MAX_SEQS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            res_mem[{wr_slot, wr_col}] <= wr_res;
            label_mem[wr_slot]         <= wr_label;
            size_mem[wr_slot]          <= wr_size;
        end
        rd_res   <= res_mem[{rd_slot, rd_col}];
        rd_label <= label_mem[rd_slot];
        rd_size  <= size_mem[rd_slot];
    end
endmodule

// File: sv/wrpc_matrix.sv
// Pair-count matrix memory; the top level runs its clearing pass after reset.
module wrpc_matrix
    import wrpc_pkg::*;
#(
    parameter int ALPHABET = ALPHABET_DEF
) (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [$clog2(ALPHABET*ALPHABET)-1:0] wr_addr,
    input  logic [ENTRY_W-1:0]                  wr_data,
    input  logic [$clog2(ALPHABET*ALPHABET)-1:0] rd_addr,
    output logic [ENTRY_W-1:0]                  rd_data
);
    logic [ENTRY_W-1:0] mem [ALPHABET*ALPHABET];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
